>>> rtl/tedm_pkg.sv
// shared constants and types for the token edit-distance match generator
// no dependencies; imported by every module of the block
package tedm_pkg;

  localparam int MAX_SUFFIX_DEF     = 32;
  localparam int MAX_TRANSITION_DEF = 32;
  localparam int TOKEN_BITS_DEF     = 24;

  localparam int FUNC_W    = 2;
  localparam int ALREADY_W = 8;
  localparam int COST_W    = 6;
  localparam int PM_W      = 9;
  localparam int TM_W      = 6;

  typedef logic [FUNC_W-1:0] func_t;

  localparam func_t FUNC_SUFFIX  = 2'd0;
  localparam func_t FUNC_TRANS   = 2'd1;
  localparam func_t FUNC_COMPUTE = 2'd2;

endpackage

>>> rtl/token_edit_distance_matches.sv
// an append writes its word from idle; compute with S suffix and T transition words:
//   first cost row, S table rows, then a read and a stall-held offer per candidate
// the table walk runs through one shared cell unit on a single-port cost row memory
// one request in flight at a time; the last candidate may wait while the next is taken
// rst_n (synchronous, active low) empties both buffers and the output register
module token_edit_distance_matches #(
  parameter int MAX_SUFFIX     = tedm_pkg::MAX_SUFFIX_DEF,
  parameter int MAX_TRANSITION = tedm_pkg::MAX_TRANSITION_DEF,
  parameter int TOKEN_BITS     = tedm_pkg::TOKEN_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  tedm_pkg::func_t                 in_func,
  input  logic [TOKEN_BITS-1:0]           in_token,
  input  logic [tedm_pkg::ALREADY_W-1:0]  in_already_matched,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [tedm_pkg::COST_W-1:0]     out_edit_cost,
  output logic [tedm_pkg::PM_W-1:0]       out_prefix_matched,
  output logic [tedm_pkg::TM_W-1:0]       out_transition_matched,
  output logic                            out_last
);
  import tedm_pkg::*;

  localparam int SW    = $clog2(MAX_SUFFIX + 1);
  localparam int TW    = $clog2(MAX_TRANSITION + 1);
  localparam int SIW   = (MAX_SUFFIX > 1) ? $clog2(MAX_SUFFIX) : 1;
  localparam int TIW   = (MAX_TRANSITION > 1) ? $clog2(MAX_TRANSITION) : 1;
  localparam int MAXST = (MAX_SUFFIX > MAX_TRANSITION) ? MAX_SUFFIX : MAX_TRANSITION;
  localparam int CW    = $clog2(MAXST + 2);

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_INIT  = 4'd1;
  localparam logic [3:0] ST_ROW   = 4'd2;
  localparam logic [3:0] ST_CRD   = 4'd3;
  localparam logic [3:0] ST_CALC  = 4'd4;
  localparam logic [3:0] ST_REND  = 4'd5;
  localparam logic [3:0] ST_E1RD  = 4'd6;
  localparam logic [3:0] ST_E1OUT = 4'd7;
  localparam logic [3:0] ST_E2RD  = 4'd8;
  localparam logic [3:0] ST_E2OUT = 4'd9;

  // buffers and table storage
  logic [TOKEN_BITS-1:0] suf_mem [MAX_SUFFIX];
  logic [TOKEN_BITS-1:0] trn_mem [MAX_TRANSITION];
  logic [CW-1:0]         row_mem [MAX_TRANSITION+1];
  logic [CW-1:0]         fcol_mem [MAX_SUFFIX];

  logic [3:0]           state_r, state_nxt;
  logic [SW-1:0]        s_cnt_r, s_cnt_nxt;
  logic [TW-1:0]        t_cnt_r, t_cnt_nxt;
  logic [SW-1:0]        i_r, i_nxt;
  logic [TW-1:0]        j_r, j_nxt;
  logic [CW-1:0]        left_r, left_nxt;
  logic [CW-1:0]        diag_r, diag_nxt;
  logic [ALREADY_W-1:0] already_r, already_nxt;

  logic                  out_valid_r, out_valid_nxt;
  logic [COST_W-1:0]     out_cost_r, out_cost_nxt;
  logic [PM_W-1:0]       out_pm_r, out_pm_nxt;
  logic [TM_W-1:0]       out_tm_r, out_tm_nxt;
  logic                  out_last_r, out_last_nxt;
  logic                  out_load;
  logic                  out_free;

  logic [TOKEN_BITS-1:0] sw_rd_r;
  logic [TOKEN_BITS-1:0] tw_rd_r;
  logic [CW-1:0]         row_rd_r;
  logic [CW-1:0]         fcol_rd_r;

  logic                  suf_we, trn_we;
  logic                  suf_re, trn_re, row_re, fcol_re;
  logic                  row_we, fcol_we;
  logic [TW-1:0]         row_waddr, row_raddr;
  logic [CW-1:0]         row_wdata;

  logic [SW-1:0]         i_m1;
  logic [TW-1:0]         j_m1;
  logic [TW-1:0]         t_m1;
  logic [CW-1:0]         best;
  logic                  in_acc;

  assign i_m1   = i_r - 1'b1;
  assign j_m1   = j_r - 1'b1;
  assign t_m1   = t_cnt_r - 1'b1;
  assign in_acc = in_valid && !in_stall;

  assign in_stall               = (state_r != ST_IDLE);
  assign out_valid              = out_valid_r;
  assign out_edit_cost          = out_cost_r;
  assign out_prefix_matched     = out_pm_r;
  assign out_transition_matched = out_tm_r;
  assign out_last               = out_last_r;
  assign out_free               = !out_valid_r || !out_stall;

  tedm_cell #(
    .CW         (CW),
    .TOKEN_BITS (TOKEN_BITS)
  ) u_cell (
    .up   (row_rd_r),
    .left (left_r),
    .diag (diag_r),
    .sw   (sw_rd_r),
    .tw   (tw_rd_r),
    .best (best)
  );

  always_comb begin
    state_nxt    = state_r;
    s_cnt_nxt    = s_cnt_r;
    t_cnt_nxt    = t_cnt_r;
    i_nxt        = i_r;
    j_nxt        = j_r;
    left_nxt     = left_r;
    diag_nxt     = diag_r;
    already_nxt  = already_r;
    out_load     = 1'b0;
    out_cost_nxt = out_cost_r;
    out_pm_nxt   = out_pm_r;
    out_tm_nxt   = out_tm_r;
    out_last_nxt = out_last_r;
    suf_we       = 1'b0;
    trn_we       = 1'b0;
    suf_re       = 1'b0;
    trn_re       = 1'b0;
    row_re       = 1'b0;
    fcol_re      = 1'b0;
    row_we       = 1'b0;
    fcol_we      = 1'b0;
    row_waddr    = j_r;
    row_raddr    = j_r;
    row_wdata    = CW'(j_r);

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          case (in_func)
            FUNC_SUFFIX: begin
              if (s_cnt_r < SW'(MAX_SUFFIX)) begin
                suf_we    = 1'b1;
                s_cnt_nxt = s_cnt_r + 1'b1;
              end
            end
            FUNC_TRANS: begin
              if (t_cnt_r < TW'(MAX_TRANSITION)) begin
                trn_we    = 1'b1;
                t_cnt_nxt = t_cnt_r + 1'b1;
              end
            end
            FUNC_COMPUTE: begin
              already_nxt = in_already_matched;
              j_nxt       = '0;
              state_nxt   = ST_INIT;
            end
            default: ;
          endcase
        end
      end
      // first row of the table: cost j
      ST_INIT: begin
        row_we    = 1'b1;
        row_waddr = j_r;
        row_wdata = CW'(j_r);
        if (j_r == t_cnt_r) begin
          if (s_cnt_r == '0) begin
            if (t_cnt_r > TW'(1)) begin
              j_nxt     = TW'(1);
              state_nxt = ST_E1RD;
            end else begin
              s_cnt_nxt = '0;
              t_cnt_nxt = '0;
              state_nxt = ST_IDLE;
            end
          end else begin
            i_nxt     = SW'(1);
            state_nxt = ST_ROW;
          end
        end else begin
          j_nxt = j_r + 1'b1;
        end
      end
      ST_ROW: begin
        suf_re    = 1'b1;
        row_we    = 1'b1;
        row_waddr = '0;
        row_wdata = CW'(i_r);
        left_nxt  = CW'(i_r);
        diag_nxt  = CW'(i_m1);
        j_nxt     = TW'(1);
        state_nxt = (t_cnt_r == '0) ? ST_REND : ST_CRD;
      end
      ST_CRD: begin
        trn_re    = 1'b1;
        row_re    = 1'b1;
        row_raddr = j_r;
        state_nxt = ST_CALC;
      end
      ST_CALC: begin
        row_we    = 1'b1;
        row_waddr = j_r;
        row_wdata = best;
        left_nxt  = best;
        diag_nxt  = row_rd_r;
        if (j_r == t_cnt_r) begin
          state_nxt = ST_REND;
        end else begin
          j_nxt     = j_r + 1'b1;
          state_nxt = ST_CRD;
        end
      end
      // left holds the last column entry of this row
      ST_REND: begin
        fcol_we = 1'b1;
        if (i_r == s_cnt_r) begin
          if (t_cnt_r > TW'(1)) begin
            j_nxt     = TW'(1);
            state_nxt = ST_E1RD;
          end else begin
            i_nxt     = SW'(1);
            state_nxt = ST_E2RD;
          end
        end else begin
          i_nxt     = i_r + 1'b1;
          state_nxt = ST_ROW;
        end
      end
      ST_E1RD: begin
        row_re    = 1'b1;
        row_raddr = j_r;
        state_nxt = ST_E1OUT;
      end
      ST_E1OUT: begin
        if (out_free) begin
          out_load     = 1'b1;
          out_cost_nxt = COST_W'(row_rd_r);
          out_pm_nxt   = PM_W'(already_r) + PM_W'(s_cnt_r);
          out_tm_nxt   = TM_W'(j_r);
          out_last_nxt = (j_r == t_m1) && (s_cnt_r == '0);
          if (j_r == t_m1) begin
            if (s_cnt_r == '0) begin
              s_cnt_nxt = '0;
              t_cnt_nxt = '0;
              state_nxt = ST_IDLE;
            end else begin
              i_nxt     = SW'(1);
              state_nxt = ST_E2RD;
            end
          end else begin
            j_nxt     = j_r + 1'b1;
            state_nxt = ST_E1RD;
          end
        end
      end
      ST_E2RD: begin
        fcol_re   = 1'b1;
        state_nxt = ST_E2OUT;
      end
      ST_E2OUT: begin
        if (out_free) begin
          out_load     = 1'b1;
          out_cost_nxt = COST_W'(fcol_rd_r);
          out_pm_nxt   = PM_W'(already_r) + PM_W'(i_r);
          out_tm_nxt   = TM_W'(t_cnt_r);
          out_last_nxt = (i_r == s_cnt_r);
          if (i_r == s_cnt_r) begin
            s_cnt_nxt = '0;
            t_cnt_nxt = '0;
            state_nxt = ST_IDLE;
          end else begin
            i_nxt     = i_r + 1'b1;
            state_nxt = ST_E2RD;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      s_cnt_r     <= '0;
      t_cnt_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      s_cnt_r     <= s_cnt_nxt;
      t_cnt_r     <= t_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    i_r        <= i_nxt;
    j_r        <= j_nxt;
    left_r     <= left_nxt;
    diag_r     <= diag_nxt;
    already_r  <= already_nxt;
    out_cost_r <= out_cost_nxt;
    out_pm_r   <= out_pm_nxt;
    out_tm_r   <= out_tm_nxt;
    out_last_r <= out_last_nxt;
  end

  always_ff @(posedge clk) begin
    if (suf_we) begin
      suf_mem[s_cnt_r[SIW-1:0]] <= in_token;
    end
    if (suf_re) begin
      sw_rd_r <= suf_mem[i_m1[SIW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (trn_we) begin
      trn_mem[t_cnt_r[TIW-1:0]] <= in_token;
    end
    if (trn_re) begin
      tw_rd_r <= trn_mem[j_m1[TIW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (row_we) begin
      row_mem[row_waddr] <= row_wdata;
    end
    if (row_re) begin
      row_rd_r <= row_mem[row_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (fcol_we) begin
      fcol_mem[i_m1[SIW-1:0]] <= left_r;
    end
    if (fcol_re) begin
      fcol_rd_r <= fcol_mem[i_m1[SIW-1:0]];
    end
  end

endmodule

>>> rtl/tedm_cell.sv
// one cell of the unit-cost edit table: min of delete, insert, substitute
// depends on tedm_pkg
module tedm_cell #(
  parameter int CW         = 7,
  parameter int TOKEN_BITS = tedm_pkg::TOKEN_BITS_DEF
) (
  input  logic [CW-1:0]         up,
  input  logic [CW-1:0]         left,
  input  logic [CW-1:0]         diag,
  input  logic [TOKEN_BITS-1:0] sw,
  input  logic [TOKEN_BITS-1:0] tw,
  output logic [CW-1:0]         best
);
  import tedm_pkg::*;

  logic [CW-1:0] del_c;
  logic [CW-1:0] ins_c;
  logic [CW-1:0] sub_c;
  logic [CW-1:0] min_di;

  always_comb begin
    del_c  = up + 1'b1;
    ins_c  = left + 1'b1;
    sub_c  = diag + CW'(sw != tw);
    min_di = (ins_c < del_c) ? ins_c : del_c;
    best   = (sub_c < min_di) ? sub_c : min_di;
  end

endmodule

>>> rtl/tedm_checker.sv
// port-level checks for token_edit_distance_matches, attached by bind
// depends on tedm_pkg
module tedm_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_valid,
  input logic                            in_stall,
  input tedm_pkg::func_t                 in_func,
  input logic                            out_valid,
  input logic                            out_stall,
  input logic [tedm_pkg::COST_W-1:0]     out_edit_cost,
  input logic [tedm_pkg::PM_W-1:0]       out_prefix_matched,
  input logic [tedm_pkg::TM_W-1:0]       out_transition_matched,
  input logic                            out_last
);
  import tedm_pkg::*;

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_edit_cost) && $stable(out_prefix_matched)
      && $stable(out_transition_matched) && $stable(out_last))
    else $error("stalled result changed");

  // appends and unused codes leave the input ready again
  a_append_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_func != FUNC_COMPUTE |=> !in_stall)
    else $error("busy after a one-cycle request");

  // a compute request always occupies the sequencer
  a_compute_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_func == FUNC_COMPUTE |=> in_stall)
    else $error("compute request did not start the table walk");

endmodule

bind token_edit_distance_matches tedm_checker u_tedm_checker (
  .clk                    (clk),
  .rst_n                  (rst_n),
  .in_valid               (in_valid),
  .in_stall               (in_stall),
  .in_func                (in_func),
  .out_valid              (out_valid),
  .out_stall              (out_stall),
  .out_edit_cost          (out_edit_cost),
  .out_prefix_matched     (out_prefix_matched),
  .out_transition_matched (out_transition_matched),
  .out_last               (out_last)
);

>>> test/tb.sv
// self-checking bench for token_edit_distance_matches: edit table candidates
// predicted in-bench from the accepted requests, checked in order at the output
// depends on tedm_pkg and the token_edit_distance_matches rtl
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tedm_pkg::*;

  localparam int MAX_S      = MAX_SUFFIX_DEF;
  localparam int MAX_T      = MAX_TRANSITION_DEF;
  localparam int TOK_W      = TOKEN_BITS_DEF;
  localparam int IDLE_LIMIT = 20000;
  localparam int DRAIN_CYC  = 40;
  localparam int REPORT_MAX = 10;
  localparam int RAND_ITEMS = 100;

  localparam func_t FUNC_UNUSED = 2'd3;

  typedef struct packed {
    func_t                func;
    logic [TOK_W-1:0]     token;
    logic [ALREADY_W-1:0] already;
  } request_t;

  typedef struct packed {
    logic [COST_W-1:0] cost;
    logic [PM_W-1:0]   prefix;
    logic [TM_W-1:0]   trans;
    logic              last;
  } candidate_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  func_t                in_func = FUNC_SUFFIX;
  logic [TOK_W-1:0]     in_token = '0;
  logic [ALREADY_W-1:0] in_already_matched = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [COST_W-1:0]    out_edit_cost;
  logic [PM_W-1:0]      out_prefix_matched;
  logic [TM_W-1:0]      out_transition_matched;
  logic                 out_last;

  request_t   request_q[$];
  candidate_t candidate_q[$];

  // predictor copy of the word buffers
  logic [TOK_W-1:0] sfx_words[0:MAX_S-1];
  logic [TOK_W-1:0] trn_words[0:MAX_T-1];
  int sfx_len = 0;
  int trn_len = 0;

  int mismatches  = 0;
  int idle_cycles = 0;
  int gap         = 0;
  int in_calm     = 0;
  int stall_left  = 0;
  int out_calm    = 0;
  int accepted    = 0;
  int total_req   = 0;

  token_edit_distance_matches u_top (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .in_valid               (in_valid),
    .in_stall               (in_stall),
    .in_func                (in_func),
    .in_token               (in_token),
    .in_already_matched     (in_already_matched),
    .out_valid              (out_valid),
    .out_stall              (out_stall),
    .out_edit_cost          (out_edit_cost),
    .out_prefix_matched     (out_prefix_matched),
    .out_transition_matched (out_transition_matched),
    .out_last               (out_last)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // wait draw per item, with occasional runs of back-to-back traffic
  task automatic draw_wait(inout int calm, output int n);
    if (calm > 0) begin
      calm--;
      n = 0;
    end else begin
      n = $urandom_range(0, 3);
      if ($urandom_range(0, 15) == 0) calm = $urandom_range(8, 24);
    end
  endtask

  // updates the word buffers; a compute fills the edit table and queues its candidates
  task automatic absorb_request(input func_t f, input logic [TOK_W-1:0] tok,
                                input logic [ALREADY_W-1:0] am);
    int row[0:MAX_T];
    int tail[0:MAX_S-1];
    int i, j, k, total, diag, up, best, sub;
    candidate_t c;
    case (f)
      FUNC_SUFFIX: begin
        if (sfx_len < MAX_S) begin
          sfx_words[sfx_len] = tok;
          sfx_len++;
        end
      end
      FUNC_TRANS: begin
        if (trn_len < MAX_T) begin
          trn_words[trn_len] = tok;
          trn_len++;
        end
      end
      FUNC_COMPUTE: begin
        for (j = 0; j <= trn_len; j++) row[j] = j;
        for (i = 1; i <= sfx_len; i++) begin
          diag = row[0];
          row[0] = i;
          for (j = 1; j <= trn_len; j++) begin
            up = row[j];
            best = up + 1;
            if (row[j-1] + 1 < best) best = row[j-1] + 1;
            sub = diag + ((sfx_words[i-1] != trn_words[j-1]) ? 1 : 0);
            if (sub < best) best = sub;
            diag = up;
            row[j] = best;
          end
          tail[i-1] = row[trn_len];
        end
        total = ((trn_len > 1) ? trn_len - 1 : 0) + sfx_len;
        k = 0;
        // whole suffix against a transition prefix
        for (j = 1; j < trn_len; j++) begin
          c.cost   = COST_W'(row[j]);
          c.prefix = PM_W'(int'(am) + sfx_len);
          c.trans  = TM_W'(j);
          c.last   = (k == total - 1);
          candidate_q = {candidate_q, c};
          k++;
        end
        // whole transition against a suffix prefix
        for (i = 1; i <= sfx_len; i++) begin
          c.cost   = COST_W'(tail[i-1]);
          c.prefix = PM_W'(int'(am) + i);
          c.trans  = TM_W'(trn_len);
          c.last   = (k == total - 1);
          candidate_q = {candidate_q, c};
          k++;
        end
        sfx_len = 0;
        trn_len = 0;
      end
      default: ;
    endcase
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        absorb_request(in_func, in_token, in_already_matched);
        accepted++;
        draw_wait(in_calm, gap);
      end
      if (!in_valid || !in_stall) begin
        if (gap > 0) begin
          gap--;
          in_valid <= 1'b0;
        end else if (request_q.size() != 0) begin
          in_func            <= request_q[0].func;
          in_token           <= request_q[0].token;
          in_already_matched <= request_q[0].already;
          void'(request_q.pop_front());
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor and checker
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall  <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (candidate_q.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_MAX)
            $display("unexpected candidate: cost %0d prefix %0d trans %0d last %0d",
                     out_edit_cost, out_prefix_matched, out_transition_matched, out_last);
        end else begin
          if (out_edit_cost !== candidate_q[0].cost ||
              out_prefix_matched !== candidate_q[0].prefix ||
              out_transition_matched !== candidate_q[0].trans ||
              out_last !== candidate_q[0].last) begin
            mismatches++;
            if (mismatches <= REPORT_MAX)
              $display("candidate mismatch: exp cost %0d prefix %0d trans %0d last %0d, %s",
                       candidate_q[0].cost, candidate_q[0].prefix, candidate_q[0].trans,
                       candidate_q[0].last,
                       $sformatf("got cost %0d prefix %0d trans %0d last %0d",
                                 out_edit_cost, out_prefix_matched,
                                 out_transition_matched, out_last));
          end
          void'(candidate_q.pop_front());
        end
        draw_wait(out_calm, stall_left);
      end else if (stall_left != 0) begin
        stall_left--;
      end
      out_stall <= (stall_left != 0);
    end
  end

  // watchdog on cycles with no request or candidate moving
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  task automatic queue_request(input func_t f, input logic [TOK_W-1:0] tok,
                               input logic [ALREADY_W-1:0] am);
    request_t r;
    r.func    = f;
    r.token   = tok;
    r.already = am;
    request_q = {request_q, r};
  endtask

  // one random load/compute sequence; tokens mostly from a small pool so words match
  task automatic queue_sequence(input int ns, input int nt, inout int count);
    logic [TOK_W-1:0] pool[0:3];
    logic [TOK_W-1:0] tok;
    logic [ALREADY_W-1:0] am;
    int a, b, p;
    for (p = 0; p < 4; p++) pool[p] = TOK_W'($urandom);
    a = 0;
    b = 0;
    while (a < ns || b < nt) begin
      tok = ($urandom_range(0, 3) != 0) ? pool[$urandom_range(0, 3)] : TOK_W'($urandom);
      if ($urandom_range(0, 19) == 0)
        queue_request(FUNC_UNUSED, TOK_W'($urandom), ALREADY_W'($urandom));
      if (b >= nt || (a < ns && $urandom_range(0, 1) == 0)) begin
        queue_request(FUNC_SUFFIX, tok, ALREADY_W'($urandom));
        a++;
      end else begin
        queue_request(FUNC_TRANS, tok, ALREADY_W'($urandom));
        b++;
      end
      count++;
    end
    // some sequences are left open and run into the next one
    if ($urandom_range(0, 4) != 0) begin
      case ($urandom_range(0, 7))
        0:       am = '0;
        1:       am = '1;
        default: am = ALREADY_W'($urandom);
      endcase
      queue_request(FUNC_COMPUTE, TOK_W'($urandom), am);
      count++;
    end
  endtask

  initial begin
    int count, seq, ns, nt;

    // directed: nothing to emit, ignored func code
    queue_request(FUNC_COMPUTE, '0, '0);
    queue_request(FUNC_UNUSED, '1, '1);
    // empty transition, top of already_matched
    queue_request(FUNC_SUFFIX, '0, '0);
    queue_request(FUNC_SUFFIX, '1, '1);
    queue_request(FUNC_SUFFIX, 24'h123456, '0);
    queue_request(FUNC_COMPUTE, '1, 8'd255);
    // single transition word
    queue_request(FUNC_TRANS, 24'hABCDEF, '0);
    queue_request(FUNC_SUFFIX, 24'hABCDEF, '0);
    queue_request(FUNC_SUFFIX, 24'h000001, '0);
    queue_request(FUNC_COMPUTE, '0, '0);
    // empty suffix
    queue_request(FUNC_TRANS, 24'd0, '0);
    queue_request(FUNC_TRANS, 24'd1, '0);
    queue_request(FUNC_TRANS, 24'd2, '0);
    queue_request(FUNC_TRANS, 24'd3, '0);
    queue_request(FUNC_COMPUTE, '0, 8'd200);
    // unused func code between loads must not disturb the buffers
    queue_request(FUNC_SUFFIX, 24'd5, '0);
    queue_request(FUNC_UNUSED, 24'd6, 8'd9);
    queue_request(FUNC_TRANS, 24'd5, '0);
    queue_request(FUNC_TRANS, 24'd6, '0);
    queue_request(FUNC_COMPUTE, 24'hFFFFFF, 8'd7);

    // random; the first two sequences overflow each buffer
    count = 0;
    seq = 0;
    while (count < RAND_ITEMS) begin
      case ((seq < 2) ? seq : $urandom_range(0, 11))
        0: begin
          ns = $urandom_range(MAX_S + 1, MAX_S + 2);
          nt = $urandom_range(0, 2);
        end
        1: begin
          ns = $urandom_range(0, 2);
          nt = $urandom_range(MAX_T + 1, MAX_T + 2);
        end
        default: begin
          ns = $urandom_range(0, 6);
          nt = $urandom_range(0, 6);
        end
      endcase
      queue_sequence(ns, nt, count);
      seq++;
    end
    // flush whatever an open sequence left behind
    queue_request(FUNC_COMPUTE, TOK_W'($urandom), ALREADY_W'($urandom));
    total_req = request_q.size();

    rst_n = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // every request absorbed means every expected candidate is queued
    while (accepted < total_req) @(posedge clk);
    while (candidate_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);

    if (mismatches == 0 && candidate_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
